@@ rtl/bhc_pkg.sv @@
// Package for the balanced Hamming codec: payload types, codes and ROM tables.
// No dependencies.
package bhc_pkg;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [13:0] code_word;
  } bhc_in_t;

  typedef struct packed {
    logic [13:0] encoded_word;
    logic [7:0]  decoded_byte;
    logic [1:0]  status;
  } bhc_out_t;

  localparam logic       FUNC_ENCODE = 1'b0;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CORR     = 2'd1;
  localparam logic [1:0] ST_UNCORR   = 2'd2;

  localparam logic [13:0] MASK_S0 = 14'h1555;
  localparam logic [13:0] MASK_S1 = 14'h0666;
  localparam logic [13:0] MASK_S2 = 14'h1878;
  localparam logic [13:0] MASK_S3 = 14'h1F80;

  // Commands from controller to datapath and status back.
  typedef struct packed {
    logic load;
    logic search;
    logic step;
  } bhc_cmd_t;

  typedef struct packed {
    logic is_encode;
    logic dbl_err;
    logic hit;
    logic last;
  } bhc_stat_t;

  localparam logic [13:0] ENC_ROM [256] = '{
    14'h2034,14'h207F,14'h01B5,14'h21D4,14'h21E7,14'h21F9,14'h01FE,14'h02B6,
    14'h22D7,14'h22E4,14'h22FA,14'h02FD,14'h031D,14'h032E,14'h0330,14'h2337,
    14'h234F,14'h2351,14'h0356,14'h2362,14'h0365,14'h037B,14'h24B7,14'h04D6,
    14'h04E5,14'h04FB,14'h24FC,14'h251C,14'h252F,14'h2531,14'h0536,14'h054E,
    14'h0550,14'h2557,14'h0563,14'h2564,14'h257A,14'h261F,14'h262C,14'h2632,
    14'h0635,14'h064D,14'h0653,14'h2654,14'h0660,14'h2667,14'h2679,14'h0780,
    14'h2787,14'h2799,14'h079E,14'h27AA,14'h07AD,14'h07B3,14'h27B4,14'h07CB,
    14'h27CC,14'h27D2,14'h27E1,14'h08BC,14'h28DD,14'h28EE,14'h28F0,14'h08F7,
    14'h0917,14'h0924,14'h093A,14'h293D,14'h2945,14'h295B,14'h095C,14'h2968,
    14'h096F,14'h0971,14'h0A14,14'h0A27,14'h0A39,14'h2A3E,14'h2A46,14'h2A58,
    14'h0A5F,14'h2A6B,14'h0A6C,14'h0A72,14'h0B8C,14'h0B92,14'h2B95,14'h0BA1,
    14'h2BA6,14'h2BB8,14'h2BC0,14'h0BC7,14'h0BD9,14'h0BEA,14'h2C15,14'h2C26,
    14'h2C38,14'h0C3F,14'h0C47,14'h0C59,14'h2C5E,14'h0C6A,14'h2C6D,14'h2C73,
    14'h2D8D,14'h2D93,14'h0D94,14'h2DA0,14'h0DA7,14'h0DB9,14'h0DC1,14'h2DC6,
    14'h2DD8,14'h2DEB,14'h2E8E,14'h2E90,14'h0E97,14'h2EA3,14'h0EA4,14'h0EBA,
    14'h0EC2,14'h2EC5,14'h2EDB,14'h2EE8,14'h0EF1,14'h2F08,14'h0F0F,14'h0F11,
    14'h0F22,14'h2F43,14'h30BD,14'h10DC,14'h10EF,14'h10F1,14'h30F6,14'h3116,
    14'h3125,14'h313B,14'h113C,14'h1144,14'h115A,14'h315D,14'h1169,14'h316E,
    14'h3170,14'h3215,14'h3226,14'h3238,14'h123F,14'h1247,14'h1259,14'h325E,
    14'h126A,14'h326D,14'h3273,14'h338D,14'h3393,14'h1394,14'h33A0,14'h13A7,
    14'h13B9,14'h13C1,14'h33C6,14'h33D8,14'h33EB,14'h1414,14'h1427,14'h1439,
    14'h343E,14'h3446,14'h3458,14'h145F,14'h346B,14'h146C,14'h1472,14'h158C,
    14'h1592,14'h3595,14'h15A1,14'h35A6,14'h35B8,14'h35C0,14'h15C7,14'h15D9,
    14'h15EA,14'h168F,14'h1691,14'h3696,14'h16A2,14'h36A5,14'h36BB,14'h36C3,
    14'h16C4,14'h16DA,14'h16E9,14'h1709,14'h370E,14'h3710,14'h3723,14'h1742,
    14'h381F,14'h382C,14'h3832,14'h1835,14'h184D,14'h1853,14'h3854,14'h1860,
    14'h3867,14'h3879,14'h3987,14'h3999,14'h199E,14'h39AA,14'h19AD,14'h19B3,
    14'h19CB,14'h39CC,14'h39D2,14'h39E1,14'h3A84,14'h3A9A,14'h1A9D,14'h3AA9,
    14'h1AAE,14'h1AB0,14'h1AC8,14'h3ACF,14'h3AD1,14'h3AE2,14'h3B02,14'h1B05,
    14'h1B1B,14'h1B28,14'h3B49,14'h1C85,14'h1C9B,14'h3C9C,14'h1CA8,14'h3CAF,
    14'h3CB1,14'h3CC9,14'h1CCE,14'h1CD0,14'h1CE3,14'h1D03,14'h3D04,14'h3D1A,
    14'h3D29,14'h1D48,14'h1E00,14'h3E07,14'h3E19,14'h3E2A,14'h1E4B,14'h3F81
  };

  localparam logic [8:0] DEC_ROM [256] = '{
    9'h007,9'h00F,9'h017,9'h01B,9'h01D,9'h01E,9'h01F,9'h027,9'h02B,9'h02D,9'h02E,9'h02F,
    9'h033,9'h035,9'h036,9'h037,9'h039,9'h03A,9'h03B,9'h03C,9'h03D,9'h03E,9'h047,9'h04B,
    9'h04D,9'h04E,9'h04F,9'h053,9'h055,9'h056,9'h057,9'h059,9'h05A,9'h05B,9'h05C,9'h05D,
    9'h05E,9'h063,9'h065,9'h066,9'h067,9'h069,9'h06A,9'h06B,9'h06C,9'h06D,9'h06E,9'h070,
    9'h071,9'h072,9'h073,9'h074,9'h075,9'h076,9'h077,9'h078,9'h079,9'h07A,9'h07C,9'h087,
    9'h08B,9'h08D,9'h08E,9'h08F,9'h093,9'h095,9'h096,9'h097,9'h099,9'h09A,9'h09B,9'h09C,
    9'h09D,9'h09E,9'h0A3,9'h0A5,9'h0A6,9'h0A7,9'h0A9,9'h0AA,9'h0AB,9'h0AC,9'h0AD,9'h0AE,
    9'h0B1,9'h0B2,9'h0B3,9'h0B4,9'h0B5,9'h0B6,9'h0B8,9'h0B9,9'h0BA,9'h0BC,9'h0C3,9'h0C5,
    9'h0C6,9'h0C7,9'h0C9,9'h0CA,9'h0CB,9'h0CC,9'h0CD,9'h0CE,9'h0D1,9'h0D2,9'h0D3,9'h0D4,
    9'h0D5,9'h0D6,9'h0D8,9'h0D9,9'h0DA,9'h0DC,9'h0E1,9'h0E2,9'h0E3,9'h0E4,9'h0E5,9'h0E6,
    9'h0E8,9'h0E9,9'h0EA,9'h0EC,9'h0EE,9'h0F0,9'h0F1,9'h0F2,9'h0F4,9'h0F8,9'h107,9'h10B,
    9'h10D,9'h10E,9'h10F,9'h113,9'h115,9'h116,9'h117,9'h119,9'h11A,9'h11B,9'h11C,9'h11D,
    9'h11E,9'h123,9'h125,9'h126,9'h127,9'h129,9'h12A,9'h12B,9'h12C,9'h12D,9'h12E,9'h131,
    9'h132,9'h133,9'h134,9'h135,9'h136,9'h138,9'h139,9'h13A,9'h13C,9'h143,9'h145,9'h146,
    9'h147,9'h149,9'h14A,9'h14B,9'h14C,9'h14D,9'h14E,9'h151,9'h152,9'h153,9'h154,9'h155,
    9'h156,9'h158,9'h159,9'h15A,9'h15C,9'h161,9'h162,9'h163,9'h164,9'h165,9'h166,9'h168,
    9'h169,9'h16A,9'h16C,9'h170,9'h171,9'h172,9'h174,9'h178,9'h183,9'h185,9'h186,9'h187,
    9'h189,9'h18A,9'h18B,9'h18C,9'h18D,9'h18E,9'h191,9'h192,9'h193,9'h194,9'h195,9'h196,
    9'h198,9'h199,9'h19A,9'h19C,9'h1A1,9'h1A2,9'h1A3,9'h1A4,9'h1A5,9'h1A6,9'h1A8,9'h1A9,
    9'h1AA,9'h1AC,9'h1B0,9'h1B1,9'h1B2,9'h1B4,9'h1B8,9'h1C1,9'h1C2,9'h1C3,9'h1C4,9'h1C5,
    9'h1C6,9'h1C8,9'h1C9,9'h1CA,9'h1CC,9'h1D0,9'h1D1,9'h1D2,9'h1D4,9'h1D8,9'h1E0,9'h1E1,
    9'h1E2,9'h1E4,9'h1E8,9'h1F0
  };

endpackage

@@ rtl/bhc_datapath.sv @@
// Datapath: encode ROM lookup, parity/syndrome check, single-bit fix and binary search over the decode ROM.
// Depends on bhc_pkg.
module bhc_datapath (
  input  logic               clk,
  input  bhc_pkg::bhc_in_t   in_word,
  input  bhc_pkg::bhc_cmd_t  cmd,
  output bhc_pkg::bhc_stat_t stat,
  output bhc_pkg::bhc_out_t  result
);
  import bhc_pkg::*;

  logic        func_r;
  logic [13:0] enc_r;
  logic [12:0] word_r, word_nxt;
  logic        perr_r, dbl_r;
  logic [8:0]  pat;
  logic [7:0]  idx_r, idx_nxt, bit_r;
  logic [3:0]  cnt_r;
  logic [3:0]  syn;
  logic        par;
  logic [8:0]  rom_v;
  logic [14:0] fixed;

  assign par = ^in_word.code_word;
  assign syn = {^(in_word.code_word & MASK_S3), ^(in_word.code_word & MASK_S2),
                ^(in_word.code_word & MASK_S1), ^(in_word.code_word & MASK_S0)};

  always_comb begin
    fixed = {1'b0, in_word.code_word};
    if (par && (syn != 4'd0)) begin
      fixed = fixed ^ (15'd1 << (syn - 4'd1));
    end
    word_nxt = fixed[12:0];
  end

  assign pat   = {word_r[12:8], word_r[6:4], word_r[2]};
  assign rom_v = DEC_ROM[idx_r];

  always_comb begin
    idx_nxt = idx_r;
    if (pat < rom_v) begin
      idx_nxt = idx_r ^ bit_r;
    end
    idx_nxt = idx_nxt | (bit_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_word.func;
      enc_r  <= ENC_ROM[in_word.data_byte];
      word_r <= word_nxt;
      perr_r <= par;
      dbl_r  <= !par && (syn != 4'd0);
      idx_r  <= 8'h80;
      bit_r  <= 8'h80;
      cnt_r  <= 4'd0;
    end else if (cmd.search && cmd.step) begin
      idx_r <= idx_nxt;
      bit_r <= bit_r >> 1;
      cnt_r <= cnt_r + 4'd1;
    end
  end

  assign stat.is_encode = (func_r == FUNC_ENCODE);
  assign stat.dbl_err   = dbl_r;
  assign stat.hit       = (pat == rom_v);
  assign stat.last      = (cnt_r == 4'd8);

  always_comb begin
    result = '0;
    if (stat.is_encode) begin
      result.encoded_word = enc_r;
    end else if (!dbl_r && stat.hit) begin
      result.decoded_byte = idx_r;
      result.status       = perr_r ? ST_CORR : ST_OK;
    end else begin
      result.status = ST_UNCORR;
    end
  end
endmodule

@@ rtl/bhc_ctrl.sv @@
// Controller: sequences load, search steps and result capture.
// Depends on bhc_pkg.
module bhc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_take,
  input  logic               out_busy,
  output logic               capture,
  output bhc_pkg::bhc_cmd_t  cmd,
  input  bhc_pkg::bhc_stat_t stat
);
  import bhc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       finish;

  assign in_ready = (state_r == S_IDLE);
  assign finish   = stat.is_encode || stat.dbl_err || stat.hit || stat.last;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    capture    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.search = 1'b1;
        if (finish) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_busy || out_take) begin
          capture   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

@@ rtl/balanced_hamming_codec.sv @@
// Balanced extended Hamming (14,9) SECDED codec top level.
// Encode and double-error words skip the search; decode runs a binary search over the decode ROM.
// A new word is accepted only once the last result is captured; the datapath search loop limits the rate.
// Output register lets the next word start while a result waits.
// Synchronous active-low reset clears control and output valid.
module balanced_hamming_codec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bhc_pkg::bhc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bhc_pkg::bhc_out_t out_data
);
  import bhc_pkg::*;

  bhc_cmd_t  cmd;
  bhc_stat_t stat;
  bhc_out_t  res;
  logic      capture;
  logic      out_valid_r;
  bhc_out_t  out_data_r;

  bhc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_take(out_ready), .out_busy(out_valid_r), .capture(capture),
    .cmd(cmd), .stat(stat)
  );

  bhc_datapath u_dp (
    .clk(clk), .in_word(in_data), .cmd(cmd), .stat(stat), .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (capture) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");
  a_enc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.encoded_word != 14'd0 |-> out_data.decoded_byte == 8'd0)
    else $error("mixed result");
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    capture |-> !out_valid || out_ready) else $error("overwrite");
endmodule
